// ===== hdl/fmd_pkg.sv =====
// Package: shared types, constants and tables for the FM demodulator.
package fmd_pkg;

  localparam int CHAN_TAPS_DEF = 64;
  localparam int MPX_TAPS_DEF  = 64;
  localparam int CORDIC_STEPS  = 15;
  localparam int REG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [REG_IDX_W-1:0] REG_FM_GAIN    = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEC_FACTOR = 1'd1;

  localparam logic [15:0] FM_GAIN_RST    = 16'd4096;
  localparam logic [4:0]  DEC_FACTOR_RST = 5'd3;

  localparam logic [1:0] MODE_SAMPLE   = 2'd0;
  localparam logic [1:0] MODE_CHAN_TAP = 2'd1;
  localparam logic [1:0] MODE_MPX_TAP  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_CMAC, ST_CDRAIN, ST_DISC_A, ST_DISC_B, ST_DISC_C,
    ST_CORDIC, ST_GAIN, ST_GAIN_B, ST_MMAC, ST_MDRAIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic        clr;
    logic        en;
  } mac_ctl_t;

  function automatic logic [13:0] cordic_angle(input logic [3:0] i);
    case (i)
      4'd0:  cordic_angle = 14'd8192;
      4'd1:  cordic_angle = 14'd4836;
      4'd2:  cordic_angle = 14'd2555;
      4'd3:  cordic_angle = 14'd1297;
      4'd4:  cordic_angle = 14'd651;
      4'd5:  cordic_angle = 14'd326;
      4'd6:  cordic_angle = 14'd163;
      4'd7:  cordic_angle = 14'd81;
      4'd8:  cordic_angle = 14'd41;
      4'd9:  cordic_angle = 14'd20;
      4'd10: cordic_angle = 14'd10;
      4'd11: cordic_angle = 14'd5;
      4'd12: cordic_angle = 14'd3;
      4'd13: cordic_angle = 14'd1;
      4'd14: cordic_angle = 14'd1;
      default: cordic_angle = 14'd0;
    endcase
  endfunction

  // round Q30 accumulator to Q15 with saturation
  function automatic logic signed [15:0] round_q15(input logic signed [47:0] acc);
    logic signed [47:0] t;
    t = (acc + 48'sd16384) >>> 15;
    if (t > 48'sd32767) round_q15 = 16'sh7fff;
    else if (t < -48'sd32768) round_q15 = -16'sh8000;
    else round_q15 = t[15:0];
  endfunction

endpackage

// ===== hdl/fmd_stream_if.sv =====
// Interfaces: valid/ready channels for input items and result items.
interface fmd_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [5:0]        tap_index;
  logic signed [15:0] tap_value;
  logic signed [15:0] i_sample;
  logic signed [15:0] q_sample;
  modport source (output valid, mode, tap_index, tap_value, i_sample, q_sample,
                  input ready);
  modport sink (input valid, mode, tap_index, tap_value, i_sample, q_sample,
                output ready);
endinterface

interface fmd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mpx_sample;
  modport source (output valid, mpx_sample, input ready);
  modport sink (input valid, mpx_sample, output ready);
endinterface

// ===== hdl/fmd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module fmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/fmd_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
module fmd_mac (
  input  logic               clk,
  input  fmd_pkg::mac_ctl_t  ctl,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic signed [47:0] acc
);
  logic signed [31:0] prod;
  logic               prod_vld;

  always_ff @(posedge clk) begin
    prod     <= a * b;
    prod_vld <= ctl.en;
    if (ctl.clr) acc <= '0;
    else if (prod_vld) acc <= acc + 48'(prod);
  end
endmodule

// ===== hdl/fmd_cordic.sv =====
// Iterative CORDIC vectoring unit: angle in units of pi/32768.
module fmd_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] x_in,
  input  logic signed [32:0] y_in,
  output logic               done,
  output logic signed [15:0] angle
);
  // x grows by about 1.65 plus the 90 degree turn: 35 bits are enough
  logic signed [35:0] x, y;
  logic signed [17:0] z;
  logic [3:0]         step;
  logic               busy;
  logic               zero_vec;
  logic signed [35:0] dx, dy;
  logic signed [35:0] xs, ys;

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign xs = 36'(x_in);
  assign ys = 36'(y_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        zero_vec <= (x_in == '0) && (y_in == '0);
        if (x_in < 0) begin
          if (y_in >= 0) begin
            x <= ys; y <= -xs; z <= 18'sd16384;
          end else begin
            x <= -ys; y <= xs; z <= -18'sd16384;
          end
        end else begin
          x <= xs; y <= ys; z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + dx; y <= y - dy; z <= z + 18'(fmd_pkg::cordic_angle(step));
        end else begin
          x <= x - dx; y <= y + dy; z <= z - 18'(fmd_pkg::cordic_angle(step));
        end
        if (step == 4'(fmd_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 4'd1;
      end
    end
  end

  always_comb begin
    if (zero_vec) angle = '0;
    else if (z > 18'sd32767) angle = 16'sh7fff;
    else if (z < -18'sd32768) angle = -16'sh8000;
    else angle = z[15:0];
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("cordic done without run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("cordic busy after done");
  a_step_zero: assert property (@(posedge clk) disable iff (rst)
    $past(start) |-> step == 4'd0) else $error("cordic step not cleared");
endmodule

// ===== hdl/fm_demod_decimating_fir.sv =====
// Top level: channel FIR, discriminator, CORDIC, gain and decimating MPX FIR.
// Processing: an IQ sample runs two channel MAC passes (I, then Q), the discriminator
// states DISC_A, DISC_B and DISC_C, the CORDIC and the gain states GAIN and GAIN_B; an
// emitted output adds an MPX MAC pass, its drain and the OUT state, which sets out_valid.
// The single shared MAC serialises the work: a new item is taken only in IDLE, once the last
// one is through; tap loads stay in IDLE. A result still held at the output stalls the next
// one in its last state. After reset the delay lines are cleared before IDLE is entered.
module fm_demod_decimating_fir #(
  parameter int CHAN_TAPS = fmd_pkg::CHAN_TAPS_DEF,
  parameter int MPX_TAPS  = fmd_pkg::MPX_TAPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  fmd_in_if.sink                           in_ch,
  fmd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [fmd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [fmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int CW = $clog2(CHAN_TAPS);
  localparam int MW = $clog2(MPX_TAPS);
  localparam int CLRN = (CHAN_TAPS > MPX_TAPS) ? CHAN_TAPS : MPX_TAPS;
  localparam int KW = $clog2(CLRN + 1);

  fmd_pkg::state_t state, state_next;

  logic [15:0] fm_gain;
  logic [4:0]  dec_factor;
  logic [CW-1:0] chan_pos;
  logic [MW-1:0] mpx_pos;
  logic [3:0]  decim_phase;
  logic signed [15:0] prev_i, prev_q, ci, cq;
  logic [KW-1:0] k;
  logic [1:0]  drain;
  logic        qpass;
  logic signed [31:0] re_p1, re_p2;
  logic signed [32:0] re, im;
  logic signed [15:0] disc;
  logic signed [31:0] scaled;
  logic        cordic_start, cordic_done;
  logic signed [15:0] angle;
  logic signed [15:0] out_data;
  logic        out_valid;
  logic        out_free;
  logic        emit;

  // memories
  logic          ct_we, cdi_we, cdq_we, mt_we, md_we;
  logic [CW-1:0] ct_waddr, cd_waddr, ct_raddr, cd_raddr;
  logic [MW-1:0] mt_waddr, md_waddr, mt_raddr, md_raddr;
  logic [15:0]   ct_rd, cdi_rd, cdq_rd, mt_rd, md_rd;
  logic [15:0]   cd_wdi, cd_wdq, md_wd;
  logic [31:0]   cd_sum, md_sum;

  fmd_ram #(.WIDTH(16), .DEPTH(CHAN_TAPS)) u_ctaps (.clk, .we(ct_we),
    .waddr(ct_waddr), .wdata(in_ch.tap_value), .raddr(ct_raddr), .rdata(ct_rd));
  fmd_ram #(.WIDTH(16), .DEPTH(CHAN_TAPS)) u_cdi (.clk, .we(cdi_we),
    .waddr(cd_waddr), .wdata(cd_wdi), .raddr(cd_raddr), .rdata(cdi_rd));
  fmd_ram #(.WIDTH(16), .DEPTH(CHAN_TAPS)) u_cdq (.clk, .we(cdq_we),
    .waddr(cd_waddr), .wdata(cd_wdq), .raddr(cd_raddr), .rdata(cdq_rd));
  fmd_ram #(.WIDTH(16), .DEPTH(MPX_TAPS)) u_mtaps (.clk, .we(mt_we),
    .waddr(mt_waddr), .wdata(in_ch.tap_value), .raddr(mt_raddr), .rdata(mt_rd));
  fmd_ram #(.WIDTH(16), .DEPTH(MPX_TAPS)) u_md (.clk, .we(md_we),
    .waddr(md_waddr), .wdata(md_wd), .raddr(md_raddr), .rdata(md_rd));

  // shared MAC
  fmd_pkg::mac_ctl_t mac_ctl;
  logic signed [15:0] mac_a, mac_b;
  logic signed [47:0] mac_acc;
  fmd_mac u_mac (.clk, .ctl(mac_ctl), .a(mac_a), .b(mac_b), .acc(mac_acc));

  fmd_cordic u_cordic (.clk, .rst, .start(cordic_start), .x_in(re), .y_in(im),
    .done(cordic_done), .angle(angle));

  logic accept, is_sample;
  assign in_ch.ready = (state == fmd_pkg::ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign is_sample = in_ch.mode == fmd_pkg::MODE_SAMPLE;
  assign out_ch.valid = out_valid;
  assign out_ch.mpx_sample = out_data;
  assign out_free = !out_valid || out_ch.ready;

  // tap loads go straight to tap RAMs
  assign ct_we = accept && in_ch.mode == fmd_pkg::MODE_CHAN_TAP
                 && 32'(in_ch.tap_index) < CHAN_TAPS;
  assign mt_we = accept && in_ch.mode == fmd_pkg::MODE_MPX_TAP
                 && 32'(in_ch.tap_index) < MPX_TAPS;
  assign ct_waddr = CW'(in_ch.tap_index);
  assign mt_waddr = MW'(in_ch.tap_index);

  logic clearing;
  assign clearing = state == fmd_pkg::ST_CLEAR;
  assign cdi_we = clearing ? (32'(k) < CHAN_TAPS) : (accept && is_sample);
  assign cdq_we = cdi_we;
  assign cd_waddr = clearing ? CW'(k) : chan_pos;
  assign cd_wdi = clearing ? 16'd0 : in_ch.i_sample;
  assign cd_wdq = clearing ? 16'd0 : in_ch.q_sample;
  assign md_we = clearing ? (32'(k) < MPX_TAPS) : (state == fmd_pkg::ST_GAIN_B);
  assign md_waddr = clearing ? MW'(k) : mpx_pos;
  assign md_wd = clearing ? 16'd0 : disc;

  // tap k meets slot pos+1+k (mod N); pos is already advanced in these states
  assign ct_raddr = CW'(k);
  assign cd_sum = 32'(chan_pos) + 32'(k);
  assign cd_raddr = CW'((cd_sum >= 32'(CHAN_TAPS)) ? cd_sum - 32'(CHAN_TAPS) : cd_sum);
  assign mt_raddr = MW'(k);
  assign md_sum = 32'(mpx_pos) + 32'(k);
  assign md_raddr = MW'((md_sum >= 32'(MPX_TAPS)) ? md_sum - 32'(MPX_TAPS) : md_sum);

  logic mac_run;
  always_comb begin
    mac_run = 1'b0;
    mac_a = ct_rd;
    mac_b = qpass ? cdq_rd : cdi_rd;
    if (state == fmd_pkg::ST_MMAC || state == fmd_pkg::ST_MDRAIN) begin
      mac_a = mt_rd;
      mac_b = md_rd;
    end
    if (state == fmd_pkg::ST_CMAC || state == fmd_pkg::ST_MMAC) mac_run = k != '0;
  end
  assign mac_ctl.en = mac_run;
  assign mac_ctl.clr = (state == fmd_pkg::ST_CMAC || state == fmd_pkg::ST_MMAC)
                       && k == '0;

  assign re = 33'(re_p1) + 33'(re_p2);
  assign cordic_start = state == fmd_pkg::ST_DISC_C;
  assign emit = decim_phase == 4'd0;

  logic [4:0] rate_eff;
  always_comb begin
    rate_eff = dec_factor;
    if (rate_eff == 5'd0) rate_eff = 5'd1;
    if (rate_eff > 5'd16) rate_eff = 5'd16;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fmd_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      fmd_pkg::ST_CLEAR:  if (32'(k) == CLRN - 1) state_next = fmd_pkg::ST_IDLE;
      fmd_pkg::ST_IDLE:   if (accept && is_sample) state_next = fmd_pkg::ST_CMAC;
      fmd_pkg::ST_CMAC:   if (32'(k) == CHAN_TAPS) state_next = fmd_pkg::ST_CDRAIN;
      fmd_pkg::ST_CDRAIN: if (drain == 2'd2)
                            state_next = qpass ? fmd_pkg::ST_DISC_A : fmd_pkg::ST_CMAC;
      fmd_pkg::ST_DISC_A: state_next = fmd_pkg::ST_DISC_B;
      fmd_pkg::ST_DISC_B: state_next = fmd_pkg::ST_DISC_C;
      fmd_pkg::ST_DISC_C: state_next = fmd_pkg::ST_CORDIC;
      fmd_pkg::ST_CORDIC: if (cordic_done) state_next = fmd_pkg::ST_GAIN;
      fmd_pkg::ST_GAIN:   state_next = fmd_pkg::ST_GAIN_B;
      fmd_pkg::ST_GAIN_B: state_next = emit ? fmd_pkg::ST_MMAC : fmd_pkg::ST_IDLE;
      fmd_pkg::ST_MMAC:   if (32'(k) == MPX_TAPS) state_next = fmd_pkg::ST_MDRAIN;
      fmd_pkg::ST_MDRAIN: if (drain == 2'd2) state_next = fmd_pkg::ST_OUT;
      fmd_pkg::ST_OUT:    if (out_free) state_next = fmd_pkg::ST_IDLE;
      default:            state_next = fmd_pkg::ST_IDLE;
    endcase
  end

  logic signed [47:0] gprod;
  logic signed [31:0] gsh;
  assign gprod = 48'(scaled) + 48'sd2048;
  assign gsh = 32'(gprod >>> 12);

  always_comb begin
    if (gsh > 32'sd32767) disc = 16'sh7fff;
    else if (gsh < -32'sd32768) disc = -16'sh8000;
    else disc = gsh[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0; drain <= '0; qpass <= 1'b0;
      chan_pos <= '0; mpx_pos <= '0; decim_phase <= '0;
      prev_i <= '0; prev_q <= '0; out_valid <= 1'b0;
      fm_gain <= fmd_pkg::FM_GAIN_RST; dec_factor <= fmd_pkg::DEC_FACTOR_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fmd_pkg::REG_FM_GAIN:    fm_gain <= cfg_data;
          fmd_pkg::REG_DEC_FACTOR: dec_factor <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state == fmd_pkg::ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        fmd_pkg::ST_CLEAR: k <= (32'(k) == CLRN - 1) ? '0 : k + 1'b1;
        fmd_pkg::ST_IDLE: if (accept && is_sample) begin
          chan_pos <= (32'(chan_pos) == CHAN_TAPS - 1) ? '0 : chan_pos + 1'b1;
          k <= '0; qpass <= 1'b0;
        end
        fmd_pkg::ST_CMAC: begin
          k <= k + 1'b1; drain <= '0;
        end
        fmd_pkg::ST_CDRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'd2) begin
            k <= '0;
            if (qpass) cq <= fmd_pkg::round_q15(mac_acc);
            else ci <= fmd_pkg::round_q15(mac_acc);
            qpass <= 1'b1;
          end
        end
        // imaginary part first, then the real part feeds the CORDIC directly
        fmd_pkg::ST_DISC_A: begin
          re_p1 <= prev_i * cq;
          re_p2 <= prev_q * ci;
        end
        fmd_pkg::ST_DISC_B: begin
          im <= 33'(re_p1) - 33'(re_p2);
          re_p1 <= prev_i * ci;
          re_p2 <= prev_q * cq;
        end
        fmd_pkg::ST_DISC_C: begin
          prev_i <= ci; prev_q <= cq;
        end
        fmd_pkg::ST_GAIN: scaled <= 32'(angle) * $signed({16'd0, fm_gain});
        fmd_pkg::ST_GAIN_B: begin
          decim_phase <= (5'(decim_phase) + 5'd1 >= rate_eff) ? 4'd0 : decim_phase + 4'd1;
          mpx_pos <= (32'(mpx_pos) == MPX_TAPS - 1) ? '0 : mpx_pos + 1'b1;
          k <= '0;
        end
        fmd_pkg::ST_MMAC: begin
          k <= k + 1'b1; drain <= '0;
        end
        fmd_pkg::ST_MDRAIN: drain <= drain + 2'd1;
        fmd_pkg::ST_OUT: if (out_free) out_data <= fmd_pkg::round_q15(mac_acc);
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == fmd_pkg::ST_IDLE) else $error("ready outside idle");
  a_out_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == fmd_pkg::ST_OUT) else $error("stray result");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    5'(decim_phase) < 5'd16) else $error("decimation phase out of range");
endmodule

// ===== verif/tb.sv =====
// Testbench for fm_demod_decimating_fir: random and directed items against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int NTAPS = 64;
  localparam int SETTLE = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam longint ANG_TBL[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                                      5, 3, 1, 1};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [fmd_pkg::REG_IDX_W-1:0] cfg_index;
  logic [fmd_pkg::CFG_DATA_W-1:0] cfg_data;

  fmd_in_if in_ch();
  fmd_out_if out_ch();

  fm_demod_decimating_fir i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [15:0] chan_hist_i[NTAPS];
  logic signed [15:0] chan_hist_q[NTAPS];
  logic signed [15:0] chan_coef[NTAPS];
  logic signed [15:0] mpx_hist[NTAPS];
  logic signed [15:0] mpx_coef[NTAPS];
  int unsigned chan_pos, mpx_pos, phase;
  logic signed [15:0] last_i, last_q;
  longint unsigned gain;
  int unsigned rate_reg;

  logic signed [15:0] mpx_expected[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;
  int hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.mode = fmd_pkg::MODE_SAMPLE;
    in_ch.tap_index = '0;
    in_ch.tap_value = '0;
    in_ch.i_sample = '0;
    in_ch.q_sample = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] to_q15(longint acc);
    return clip16((acc + 16384) >>> 15);
  endfunction

  // CORDIC vectoring, angle in units of pi/32768
  function automatic logic signed [15:0] vec_angle(longint x, longint y);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 16'sd0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 16384;
      end else begin
        t = x; x = -y; y = t; z = -16384;
      end
    end
    for (int i = 0; i < 15; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ANG_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ANG_TBL[i];
      end
    end
    return clip16(z);
  endfunction

  task automatic reset_model();
    for (int k = 0; k < NTAPS; k++) begin
      chan_hist_i[k] = 0; chan_hist_q[k] = 0; mpx_hist[k] = 0;
      chan_coef[k] = 0; mpx_coef[k] = 0;
    end
    chan_pos = 0; mpx_pos = 0; phase = 0;
    last_i = 0; last_q = 0;
    gain = fmd_pkg::FM_GAIN_RST;
    rate_reg = fmd_pkg::DEC_FACTOR_RST;
  endtask

  task automatic predict_mpx(logic [1:0] mode, logic [5:0] idx, logic signed [15:0] coef,
                             logic signed [15:0] si, logic signed [15:0] sq);
    longint acc_i, acc_q, acc, re, im;
    logic signed [15:0] ci, cq, ang, disc;
    int unsigned s, rate;
    bit emit;
    acc_i = 0; acc_q = 0; acc = 0;
    if (mode == fmd_pkg::MODE_CHAN_TAP) chan_coef[idx] = coef;
    else if (mode == fmd_pkg::MODE_MPX_TAP) mpx_coef[idx] = coef;
    else if (mode == fmd_pkg::MODE_SAMPLE) begin
      chan_hist_i[chan_pos] = si;
      chan_hist_q[chan_pos] = sq;
      for (int k = 0; k < NTAPS; k++) begin
        s = (chan_pos + 1 + k) % NTAPS;
        acc_i += longint'(chan_coef[k]) * chan_hist_i[s];
        acc_q += longint'(chan_coef[k]) * chan_hist_q[s];
      end
      chan_pos = (chan_pos + 1) % NTAPS;
      ci = to_q15(acc_i);
      cq = to_q15(acc_q);
      re = longint'(last_i) * ci + longint'(last_q) * cq;
      im = longint'(last_i) * cq - longint'(last_q) * ci;
      last_i = ci;
      last_q = cq;
      ang = vec_angle(re, im);
      disc = clip16((longint'(ang) * longint'(gain) + 2048) >>> 12);
      mpx_hist[mpx_pos] = disc;
      emit = (phase == 0);
      if (emit) begin
        for (int k = 0; k < NTAPS; k++) begin
          s = (mpx_pos + 1 + k) % NTAPS;
          acc += longint'(mpx_coef[k]) * mpx_hist[s];
        end
        mpx_expected.push_back(to_q15(acc));
      end
      rate = (rate_reg == 0) ? 1 : (rate_reg > 16) ? 16 : rate_reg;
      phase++;
      if (phase >= rate) phase = 0;
      mpx_pos = (mpx_pos + 1) % NTAPS;
    end
  endtask

  // called at a rising edge, returns at a rising edge
  task automatic send_item(logic [1:0] mode, logic [5:0] idx, logic signed [15:0] coef,
                           logic signed [15:0] si, logic signed [15:0] sq);
    int gap;
    in_ch.valid <= 1;
    in_ch.mode <= mode;
    in_ch.tap_index <= idx;
    in_ch.tap_value <= coef;
    in_ch.i_sample <= si;
    in_ch.q_sample <= sq;
    do @(posedge clk); while (!in_ch.ready);
    predict_mpx(mode, idx, coef, si, sq);
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [fmd_pkg::REG_IDX_W-1:0] idx,
                           logic [fmd_pkg::CFG_DATA_W-1:0] val);
    in_ch.valid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == fmd_pkg::REG_FM_GAIN) gain = val;
    else if (idx == fmd_pkg::REG_DEC_FACTOR) rate_reg = val[4:0];
  endtask

  // sender pauses until the block has gone quiet
  task automatic wait_drained();
    in_ch.valid <= 0;
    while (mpx_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
      1, 2, 3: return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
      default: return $signed(16'($urandom_range(0, 3000))) - 16'sd1500;
    endcase
  endfunction

  task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq);
    send_item(fmd_pkg::MODE_SAMPLE, 6'($urandom), 16'($urandom), si, sq);
  endtask

  task automatic load_all_taps();
    for (int k = 0; k < NTAPS; k++)
      send_item(fmd_pkg::MODE_CHAN_TAP, k, rand_coef(), 16'($urandom), 16'($urandom));
    for (int k = 0; k < NTAPS; k++)
      send_item(fmd_pkg::MODE_MPX_TAP, k, rand_coef(), 16'($urandom), 16'($urandom));
  endtask

  // receiver: random stall before each transfer, or one long hold-off on request
  initial begin
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 13);
      if (hold_off > 0) begin
        w = hold_off;
        hold_off = 0;
      end
      if (w > 0) begin
        out_ch.ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (mpx_expected.size() == 0) begin
        $display("%0t: unexpected mpx_sample %0d", $time, out_ch.mpx_sample);
        errors++;
      end else begin
        if (out_ch.mpx_sample !== mpx_expected[0]) begin
          $display("%0t: mpx_sample expected %0d actual %0d", $time, mpx_expected[0],
                   out_ch.mpx_sample);
          errors++;
        end
        void'(mpx_expected.pop_front());
      end
    end
  end

  // a delta channel filter and a two-tap MPX filter make the discriminator path visible; corner vectors
  task automatic test_directed();
    for (int k = 0; k < NTAPS; k++) begin
      send_item(fmd_pkg::MODE_CHAN_TAP, k, (k == NTAPS - 1) ? 16'sh7fff : 16'sd0, 0, 0);
      send_item(fmd_pkg::MODE_MPX_TAP, k, (k == NTAPS - 1) ? 16'sh7fff : 16'sd0, 0, 0);
    end
    send_item(fmd_pkg::MODE_MPX_TAP, 6'd0, -16'sh8000, 0, 0);
    send_item(MODE_UNUSED, 6'd63, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    write_reg(fmd_pkg::REG_DEC_FACTOR, 1);
    send_sample(0, 0);
    send_sample(16'sh7fff, 0);
    send_sample(-16'sh8000, 0);
    send_sample(0, 16'sh7fff);
    send_sample(-16'sh7fff, -16'sd1);
    send_sample(-16'sh7fff, 16'sd1);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(0, 0);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sd1000, 16'sd10);
    send_sample(16'sd1000, -16'sd10);
    wait_drained();
  endtask

  task automatic run_phase(int n, logic [15:0] g, logic [4:0] r);
    write_reg(fmd_pkg::REG_FM_GAIN, g);
    write_reg(fmd_pkg::REG_DEC_FACTOR, r);
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(0, 39))
        0: send_item(fmd_pkg::MODE_CHAN_TAP, 6'($urandom), rand_coef(), 16'($urandom),
                     16'($urandom));
        1: send_item(fmd_pkg::MODE_MPX_TAP, 6'($urandom), rand_coef(), 16'($urandom),
                     16'($urandom));
        2: send_item(MODE_UNUSED, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: send_sample(rand_sample(), rand_sample());
      endcase
    end
    wait_drained();
  endtask

  task automatic test_config_extremes();
    run_phase(30, 16'd0, 5'd1);
    run_phase(30, 16'hffff, 5'd16);
    run_phase(30, 16'd1, 5'd0);
    run_phase(30, 16'd4096, 5'd31);
  endtask

  task automatic test_random();
    load_all_taps();
    run_phase(100, 16'($urandom), 5'($urandom_range(1, 16)));
    no_idle = 1;
    run_phase(80, 16'($urandom_range(2048, 16384)), 5'($urandom_range(1, 4)));
    no_idle = 0;
    run_phase(80, 16'($urandom_range(0, 12288)), 5'($urandom_range(1, 3)));
    run_phase(50, 16'($urandom), 5'($urandom));
  endtask

  task automatic test_backpressure();
    write_reg(fmd_pkg::REG_DEC_FACTOR, 1);
    hold_off = 3000;
    for (int j = 0; j < 40; j++) send_sample(rand_sample(), rand_sample());
    wait_drained();
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    load_all_taps();
    test_config_extremes();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fmd_pkg.sv
hdl/fmd_stream_if.sv
hdl/fmd_ram.sv
hdl/fmd_mac.sv
hdl/fmd_cordic.sv
hdl/fm_demod_decimating_fir.sv
verif/tb.sv
